[hw/rtl/dcs_pkg.sv]
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, defaults and result codes of the discrete CDF sampler.
// ----------------------------------------------------------------------------
package dcs_pkg;

	localparam int KEY_W             = 24;
	localparam int STATUS_W          = 3;
	localparam int DEF_TABLE_DEPTH   = 256;
	localparam int DEF_FRACTION_BITS = 16;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND  = 3'd0,
		ST_NONE   = 3'd1,
		ST_STORED = 3'd2,
		ST_DUP    = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

endpackage

[hw/rtl/dcs_in_if.sv]
// ----------------------------------------------------------------------------
// dcs_in_if
// Request channel: load a table entry or draw a sample.
// ----------------------------------------------------------------------------
interface dcs_in_if #(
	parameter int WEIGHT_W = dcs_pkg::DEF_FRACTION_BITS + 1,
	parameter int UNIF_W   = dcs_pkg::DEF_FRACTION_BITS
);
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [dcs_pkg::KEY_W-1:0] entry_key;
	logic [WEIGHT_W-1:0]     entry_weight;
	logic [UNIF_W-1:0]       uniform_value;

	modport source (
		output valid, action, entry_key, entry_weight, uniform_value,
		input  ready
	);

	modport sink (
		input  valid, action, entry_key, entry_weight, uniform_value,
		output ready
	);
endinterface

[hw/rtl/dcs_out_if.sv]
// ----------------------------------------------------------------------------
// dcs_out_if
// Result channel: chosen key and status code.
// ----------------------------------------------------------------------------
interface dcs_out_if;
	logic                         valid;
	logic                         ready;
	logic [dcs_pkg::KEY_W-1:0]    sampled_key;
	logic [dcs_pkg::STATUS_W-1:0] status;

	modport source (
		output valid, sampled_key, status,
		input  ready
	);

	modport sink (
		input  valid, sampled_key, status,
		output ready
	);
endinterface

[hw/rtl/dcs_ram.sv]
// ----------------------------------------------------------------------------
// dcs_ram
// Simple dual-port table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcs_ram #(
	parameter int DEPTH = dcs_pkg::DEF_TABLE_DEPTH,
	parameter int WIDTH = dcs_pkg::KEY_W + dcs_pkg::DEF_FRACTION_BITS + 1,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/discrete_cdf_sampler_top.sv]
// ----------------------------------------------------------------------------
// discrete_cdf_sampler_top
// Inverse-transform sampler over a key-sorted table of weighted entries.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one item per valid/ready handshake. action 0 loads
//   (entry_key, entry_weight) at its sorted place; action 1 draws a sample
//   with uniform_value. dout returns exactly one item per request:
//   sampled_key and status (found, none, stored, duplicate, full).
// Operation (N = entries held, P = insert position):
//   sample: one table read per cycle while summing.
//   load:   a key that is appended or rejected needs no shift; an
//           insert at P takes a scan that reads P + 1 entries,
//           then the N - P higher entries move up one slot with one read
//           and one write of the table memory per cycle.
//   One request is in work at a time; din.ready is high while idle.
// Reset: arst_n empties the table (entry count zero) and drops the output
//   item. The table memory itself is not cleared.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile, and its result is held until dout drains.
// ----------------------------------------------------------------------------
module discrete_cdf_sampler_top #(
	parameter int TABLE_DEPTH   = dcs_pkg::DEF_TABLE_DEPTH,
	parameter int FRACTION_BITS = dcs_pkg::DEF_FRACTION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	dcs_in_if.sink        din,
	dcs_out_if.source     dout
);

	localparam int KW = dcs_pkg::KEY_W;
	localparam int WW = FRACTION_BITS + 1;
	localparam int UW = FRACTION_BITS;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = WW + AW + 1;
	localparam int DW = KW + WW;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_PUT   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               pend_s1;
	logic [AW-1:0]      idx_s1;
	logic               iss_q;
	logic               out_vld_q;

	dcs_pkg::action_t   op_q;
	logic [KW-1:0]      key_q;
	logic [WW-1:0]      weight_q;
	logic [UW-1:0]      u_q;
	logic [CW-1:0]      raddr_q;
	logic [CW-1:0]      pos_q;
	logic [SW-1:0]      sum_q;
	logic [KW-1:0]      res_key_q;
	dcs_pkg::status_t   res_st_q;
	logic [KW-1:0]      out_key_q;
	dcs_pkg::status_t   out_st_q;

	logic               accept;
	logic               out_free;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DW-1:0]      ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DW-1:0]      ram_rdata;
	logic [KW-1:0]      rd_key;
	logic [WW-1:0]      rd_wt;
	logic [SW-1:0]      sum_nxt;
	logic               hit;
	logic               last_s1;
	logic               full;
	logic               scan_end;

	assign din.ready   = (state_q == S_IDLE);
	assign accept      = din.valid && din.ready;
	assign out_free    = !out_vld_q || dout.ready;

	assign dout.valid       = out_vld_q;
	assign dout.sampled_key = out_key_q;
	assign dout.status      = out_st_q;

	assign rd_key  = ram_rdata[DW-1:WW];
	assign rd_wt   = ram_rdata[WW-1:0];
	assign sum_nxt = sum_q + SW'(rd_wt);
	assign hit     = sum_nxt >= SW'(u_q);
	assign last_s1 = CW'(idx_s1) == (count_q - CW'(1));
	assign full    = count_q == CW'(TABLE_DEPTH);

	always_comb begin
		scan_end = 1'b0;
		if (state_q == S_SCAN && pend_s1) begin
			if (op_q == dcs_pkg::ACT_SAMPLE) begin
				scan_end = hit || last_s1;
			end else begin
				scan_end = (rd_key >= key_q) || last_s1;
			end
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = raddr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = {key_q, weight_q};
		case (state_q)
			S_IDLE: begin
				ram_re    = accept && (count_q != '0);
				ram_raddr = '0;
			end
			S_SCAN: begin
				ram_re = (raddr_q < count_q) && !scan_end;
			end
			S_SHIFT: begin
				ram_re    = iss_q;
				ram_we    = pend_s1;
				ram_waddr = idx_s1 + AW'(1);
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	dcs_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (DW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pend_s1   <= 1'b0;
			iss_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			pend_s1 <= ram_re;
			if (state_q == S_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (count_q != '0) begin
							state_q <= S_SCAN;
						end else if (din.action == dcs_pkg::ACT_SAMPLE) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PUT;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						if (op_q == dcs_pkg::ACT_SAMPLE || rd_key == key_q || full) begin
							state_q <= S_DONE;
						end else if (rd_key > key_q) begin
							state_q <= S_SHIFT;
							iss_q   <= 1'b1;
						end else begin
							state_q <= S_PUT;
						end
					end
				end
				S_SHIFT: begin
					if (iss_q && raddr_q == pos_q) begin
						iss_q <= 1'b0;
					end
					if (pend_s1 && CW'(idx_s1) == pos_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= ram_raddr;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= dcs_pkg::action_t'(din.action);
					key_q     <= din.entry_key;
					weight_q  <= din.entry_weight;
					u_q       <= din.uniform_value;
					raddr_q   <= CW'(1);
					pos_q     <= '0;
					sum_q     <= '0;
					res_key_q <= '0;
					res_st_q  <= (din.action == dcs_pkg::ACT_SAMPLE) ?
					             dcs_pkg::ST_NONE : dcs_pkg::ST_STORED;
				end
			end
			S_SCAN: begin
				if (ram_re) begin
					raddr_q <= raddr_q + CW'(1);
				end
				if (scan_end) begin
					raddr_q <= count_q - CW'(1);
				end
				if (pend_s1) begin
					if (op_q == dcs_pkg::ACT_SAMPLE) begin
						sum_q <= sum_nxt;
						if (hit) begin
							res_key_q <= rd_key;
							res_st_q  <= dcs_pkg::ST_FOUND;
						end
					end else begin
						if (rd_key == key_q) begin
							res_st_q <= dcs_pkg::ST_DUP;
						end else if (scan_end && full) begin
							res_st_q <= dcs_pkg::ST_FULL;
						end
						if (rd_key > key_q) begin
							pos_q <= CW'(idx_s1);
						end else if (last_s1) begin
							pos_q <= count_q;
						end
					end
				end
			end
			S_SHIFT: begin
				if (iss_q) begin
					raddr_q <= raddr_q - CW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_key_q <= res_key_q;
					out_st_q  <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");

	a_count_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_PUT) |=> $stable(count_q))
		else $error("entry count changed outside insert");

	a_port_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("shift read and write hit the same entry");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SHIFT || state_q == S_PUT))
		else $error("table write outside shift or insert");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the discrete CDF sampler. A directed list covers the
// empty table, extreme keys and weights, duplicates and zero-weight ties. A
// long random run of inserts and draws follows, some draws aimed at running
// sums, then a full table is tested. Results are held to an in-bench model of
// the sorted weight list or listed values. Channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import dcs_pkg::*;

	localparam int DEPTH        = DEF_TABLE_DEPTH;
	localparam int WEIGHT_W     = DEF_FRACTION_BITS + 1;
	localparam int UNIF_W       = DEF_FRACTION_BITS;
	localparam int RANDOM_ITEMS = 750;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 64;
	localparam int CYCLE_LIMIT  = 3_000_000;

	typedef struct packed {
		action_t             act;
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
		logic [UNIF_W-1:0]   u;
		logic                typed;
		logic [KEY_W-1:0]    want_key;
		status_t             want_st;
	} stim_row_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		status_t          st;
	} draw_result_t;

	localparam int N_DIRECTED = 21;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'h0000, 1'b1, 24'h000000, ST_NONE},
		'{ACT_SAMPLE, 24'hFFFFFF, 17'h1FFFF, 16'hFFFF, 1'b1, 24'h000000, ST_NONE},
		'{ACT_LOAD,   24'h000000, 17'h00000, 16'h0000, 1'b1, 24'h000000, ST_STORED},
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'h0000, 1'b1, 24'h000000, ST_FOUND},
		'{ACT_SAMPLE, 24'hFFFFFF, 17'h1FFFF, 16'h0001, 1'b1, 24'h000000, ST_NONE},
		'{ACT_LOAD,   24'hFFFFFF, 17'h1FFFF, 16'hFFFF, 1'b1, 24'h000000, ST_STORED},
		'{ACT_LOAD,   24'h000000, 17'h00005, 16'h0000, 1'b1, 24'h000000, ST_DUP},
		'{ACT_LOAD,   24'hFFFFFF, 17'h00000, 16'h0000, 1'b1, 24'h000000, ST_DUP},
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'hFFFF, 1'b1, 24'hFFFFFF, ST_FOUND},
		'{ACT_LOAD,   24'h800000, 17'h10000, 16'h0000, 1'b1, 24'h000000, ST_STORED},
		'{ACT_LOAD,   24'h7FFFFF, 17'h00000, 16'h0000, 1'b1, 24'h000000, ST_STORED},
		'{ACT_LOAD,   24'h000001, 17'h08000, 16'h0000, 1'b1, 24'h000000, ST_STORED},
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'h8000, 1'b0, 24'h000000, ST_FOUND},
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'h8001, 1'b0, 24'h000000, ST_FOUND},
		'{ACT_SAMPLE, 24'hFFFFFF, 17'h1FFFF, 16'h0000, 1'b1, 24'h000000, ST_FOUND},
		'{ACT_LOAD,   24'h000002, 17'h00000, 16'hFFFF, 1'b0, 24'h000000, ST_STORED},
		'{ACT_SAMPLE, 24'h000000, 17'h00000, 16'h8000, 1'b0, 24'h000000, ST_FOUND},
		'{ACT_LOAD,   24'h555555, 17'h0AAAA, 16'hAAAA, 1'b0, 24'h000000, ST_STORED},
		'{ACT_SAMPLE, 24'hAAAAAA, 17'h15555, 16'h5555, 1'b0, 24'h000000, ST_FOUND},
		'{ACT_LOAD,   24'hAAAAAA, 17'h15555, 16'h5555, 1'b0, 24'h000000, ST_STORED},
		'{ACT_SAMPLE, 24'h555555, 17'h0AAAA, 16'hAAAA, 1'b0, 24'h000000, ST_FOUND}
	};

	logic clk;
	logic arst_n;

	dcs_in_if  din ();
	dcs_out_if dout ();

	discrete_cdf_sampler_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	logic [KEY_W-1:0]    model_keys    [DEPTH];
	logic [WEIGHT_W-1:0] model_weights [DEPTH];
	int                  model_count;
	draw_result_t        expected_q [$];
	int                  errors;
	int                  cycles;
	bit                  steady;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic draw_result_t cdf_apply(input action_t act,
			input logic [KEY_W-1:0] key, input logic [WEIGHT_W-1:0] weight,
			input logic [UNIF_W-1:0] u);
		draw_result_t    r;
		int              pos;
		longint unsigned sum;
		r.key = '0;
		r.st  = ST_NONE;
		if (act == ACT_LOAD) begin
			pos = 0;
			while (pos < model_count && model_keys[pos] < key)
				pos++;
			if (pos < model_count && model_keys[pos] == key) begin
				r.st = ST_DUP;
			end else if (model_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				for (int i = model_count; i > pos; i--) begin
					model_keys[i]    = model_keys[i-1];
					model_weights[i] = model_weights[i-1];
				end
				model_keys[pos]    = key;
				model_weights[pos] = weight;
				model_count++;
				r.st = ST_STORED;
			end
		end else begin
			sum = 0;
			for (int i = 0; i < model_count; i++) begin
				sum += model_weights[i];
				if (sum >= u) begin
					r.key = model_keys[i];
					r.st  = ST_FOUND;
					break;
				end
			end
		end
		return r;
	endfunction

	function automatic bit key_present(input logic [KEY_W-1:0] key);
		for (int i = 0; i < model_count; i++)
			if (model_keys[i] == key)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic send_item(input action_t act, input logic [KEY_W-1:0] key,
			input logic [WEIGHT_W-1:0] weight, input logic [UNIF_W-1:0] u,
			input bit typed, input logic [KEY_W-1:0] want_key, input status_t want_st);
		draw_result_t pred;
		while (!steady && $urandom_range(0, 99) < 24) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid         <= 1'b1;
		din.action        <= act;
		din.entry_key     <= key;
		din.entry_weight  <= weight;
		din.uniform_value <= u;
		do
			@(posedge clk);
		while (!din.ready);
		pred = cdf_apply(act, key, weight, u);
		if (typed) begin
			pred.key = want_key;
			pred.st  = want_st;
		end
		expected_q.push_back(pred);
	endtask

	task automatic hold_until_drained();
		din.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		int                  pick;
		int                  idx;
		longint unsigned     s;
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
		logic [UNIF_W-1:0]   u;
		pick   = $urandom_range(0, 99);
		key    = KEY_W'($urandom);
		weight = WEIGHT_W'($urandom);
		u      = UNIF_W'($urandom);
		if (pick < 45) begin
			if ($urandom_range(0, 1))
				key = KEY_W'($urandom_range(0, 1023));
			pick = $urandom_range(0, 99);
			if (pick < 8)
				weight = '0;
			else if (pick >= 11)
				weight = WEIGHT_W'($urandom_range(0, 600));
			send_item(ACT_LOAD, key, weight, u, 1'b0, '0, ST_STORED);
		end else if (pick < 55 && model_count > 0) begin
			key = model_keys[$urandom_range(0, model_count - 1)];
			send_item(ACT_LOAD, key, weight, u, 1'b0, '0, ST_DUP);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				u = UNIF_W'($urandom_range(0, 255));
			end else if (pick < 50 && model_count > 0) begin
				// aim at a running sum, one below, on, or one above
				idx = $urandom_range(0, model_count - 1);
				s   = 0;
				for (int i = 0; i <= idx; i++)
					s += model_weights[i];
				s = s + $urandom_range(0, 2);
				if (s > 0)
					s = s - 1;
				u = (s > 64'hFFFF) ? 16'hFFFF : s[UNIF_W-1:0];
			end
			send_item(ACT_SAMPLE, key, weight, u, 1'b0, '0, ST_FOUND);
		end
	endtask

	always @(posedge clk) begin
		dout.ready <= steady || ($urandom_range(0, 99) >= 24);
	end

	always @(posedge clk) begin : result_check
		draw_result_t want;
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result key %h status %0d",
					dout.sampled_key, dout.status));
			end else begin
				want = expected_q.pop_front();
				if (dout.sampled_key !== want.key)
					report_mismatch($sformatf("sampled_key %h, want %h",
						dout.sampled_key, want.key));
				if (dout.status !== want.st)
					report_mismatch($sformatf("status %0d, want %0d",
						dout.status, want.st));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] key;
		arst_n            = 1'b0;
		steady            = 1'b0;
		errors            = 0;
		cycles            = 0;
		model_count       = 0;
		din.valid         = 1'b0;
		din.action        = ACT_LOAD;
		din.entry_key     = '0;
		din.entry_weight  = '0;
		din.uniform_value = '0;
		dout.ready        = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].weight,
				DIRECTED_ROWS[i].u, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want_key,
				DIRECTED_ROWS[i].want_st);
		hold_until_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 300 && n < 420);
			random_item();
		end
		steady = 1'b0;

		// top up to a full table, then hit it with new and known keys
		while (model_count < DEPTH) begin
			do
				key = KEY_W'($urandom);
			while (key_present(key));
			send_item(ACT_LOAD, key, WEIGHT_W'($urandom_range(0, 300)), UNIF_W'($urandom),
				1'b0, '0, ST_STORED);
		end
		do
			key = KEY_W'($urandom);
		while (key_present(key));
		send_item(ACT_LOAD, key, 17'h1FFFF, 16'hFFFF, 1'b1, '0, ST_FULL);
		send_item(ACT_LOAD, model_keys[0], 17'h00000, 16'h0000, 1'b1, '0, ST_DUP);
		send_item(ACT_LOAD, model_keys[DEPTH-1], 17'h1FFFF, 16'hFFFF, 1'b1, '0, ST_DUP);
		send_item(ACT_SAMPLE, 24'hFFFFFF, 17'h1FFFF, 16'h0000, 1'b1, model_keys[0], ST_FOUND);
		send_item(ACT_SAMPLE, 24'h000000, 17'h00000, 16'hFFFF, 1'b0, '0, ST_FOUND);

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
